/* rtl/core/moving_window_power_sums_core_macros.svh */
`ifndef MOVING_WINDOW_POWER_SUMS_CORE_MACROS_SVH
`define MOVING_WINDOW_POWER_SUMS_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MWPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MWPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mwps_pkg.sv */
`default_nettype none
package mwps_pkg;

  localparam int NPOW = 5;

  localparam logic [1:0] MODE_ACC = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_CLR = 2'd2;

  localparam logic REG_HIGHEST_POWER = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  localparam logic signed [3:0] HP_MAX   = 4'sd4;
  localparam logic signed [3:0] HP_MIN   = -4'sd1;
  localparam logic signed [3:0] HP_RESET = 4'sd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD,
    ST_RD_OLD,
    ST_LD_OLD,
    ST_SUB,
    ST_WR,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_OUT
  } mwps_state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic rd_slot;
    logic load_old;
    logic wr_ring;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } mwps_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       win;
    logic       full;
    logic       pow_done;
    logic       scan_done;
  } mwps_sts_t;

endpackage
`default_nettype wire

/* rtl/core/mwps_in_if.sv */
`default_nettype none
interface mwps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [11:0] sample;
  logic [7:0]         weight;

  modport source (output valid, mode, sample, weight, input ready);
  modport sink (input valid, mode, sample, weight, output ready);
endinterface
`default_nettype wire

/* rtl/core/mwps_out_if.sv */
`default_nettype none
interface mwps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count;
  logic signed [63:0] sum_power0;
  logic signed [63:0] sum_power1;
  logic signed [63:0] sum_power2;
  logic signed [63:0] sum_power3;
  logic signed [63:0] sum_power4;
  logic signed [11:0] data_min;
  logic signed [11:0] data_max;
  logic               overflow_flag;
  logic               error_flag;

  modport source (output valid, count, sum_power0, sum_power1, sum_power2, sum_power3,
                  sum_power4, data_min, data_max, overflow_flag, error_flag,
                  input ready);
  modport sink (input valid, count, sum_power0, sum_power1, sum_power2, sum_power3,
                sum_power4, data_min, data_max, overflow_flag, error_flag,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/mwps_datapath.sv */
`default_nettype none
module mwps_datapath #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mwps_pkg::mwps_cmd_t cmd,
  output mwps_pkg::mwps_sts_t     sts,
  input  wire logic [1:0]         in_mode,
  input  wire logic [11:0]        in_sample,
  input  wire logic [7:0]         in_weight,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [31:0]        cfg_wdata,
  output logic [3:0]              cfg_hp,
  output logic [10:0]             cfg_wl,
  output logic signed [31:0]      out_count,
  output logic signed [63:0]      out_sum_power0,
  output logic signed [63:0]      out_sum_power1,
  output logic signed [63:0]      out_sum_power2,
  output logic signed [63:0]      out_sum_power3,
  output logic signed [63:0]      out_sum_power4,
  output logic signed [11:0]      out_data_min,
  output logic signed [11:0]      out_data_max,
  output logic                    out_overflow_flag,
  output logic                    out_error_flag
);

  localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (LEN_W > 11) ? LEN_W : 11;
  localparam int PROD_W = 8 + 4 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] ring_s [WINDOW_DEPTH];
  logic [7:0]                    ring_w [WINDOW_DEPTH];

  logic signed [3:0]             hp_r;
  logic [10:0]                   wl_r;
  logic [31:0]                   cnt_r;
  logic [63:0]                   sum_r [mwps_pkg::NPOW];
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic                          ovf_r;
  logic [AW-1:0]                 slot_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [7:0]                    w_r;
  logic [1:0]                    mode_r;
  logic                          err_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [SAMPLE_BITS-1:0] mx_r;
  logic [2:0]                    k_r;
  logic                          neg_r;
  logic [LEN_W-1:0]              scan_i_r;
  logic                          first_r;
  logic                          rd_v_r;
  logic signed [SAMPLE_BITS-1:0] rd_s_r;
  logic [7:0]                    rd_w_r;

  logic signed [3:0]             hp_eff;
  logic [CMP_W-1:0]              len_c;
  logic [LEN_W-1:0]              len;
  logic                          win;
  logic                          full;
  logic [LEN_W-1:0]              scan_n;
  logic                          scan_more;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic [63:0]                   sum_a, sum_b, sum_res;
  logic                          sum_ovf;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic [LEN_W:0]                slot_p1;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;

  always_comb begin
    if (hp_r > mwps_pkg::HP_MAX) begin
      hp_eff = mwps_pkg::HP_MAX;
    end else if (hp_r < mwps_pkg::HP_MIN) begin
      hp_eff = mwps_pkg::HP_MIN;
    end else begin
      hp_eff = hp_r;
    end
    len_c = (CMP_W'(wl_r) > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : CMP_W'(wl_r);
  end

  assign len       = LEN_W'(len_c);
  assign win       = (len != '0);
  assign full      = (cnt_r >= 32'(len));
  assign scan_n    = win ? LEN_W'(cnt_r) : '0;
  assign scan_more = (scan_i_r < scan_n);
  assign x_in      = $signed(in_sample[SAMPLE_BITS-1:0]);
  assign sum_a     = sum_r[k_r];
  assign sum_b     = 64'(prod_r);
  assign sum_res   = neg_r ? (sum_a - sum_b) : (sum_a + sum_b);
  assign sum_ovf   = neg_r ? ((sum_a[63] != sum_b[63]) && (sum_res[63] != sum_a[63]))
                           : ((sum_a[63] == sum_b[63]) && (sum_res[63] != sum_a[63]));
  assign prod_nxt  = PROD_W'(prod_r * mx_r);
  assign slot_p1   = (LEN_W+1)'(slot_r) + (LEN_W+1)'(1);
  assign rd_en     = cmd.rd_slot || (cmd.scan_step && scan_more);
  assign rd_addr   = cmd.rd_slot ? slot_r : scan_i_r[AW-1:0];

  assign sts.mode      = mode_r;
  assign sts.win       = win;
  assign sts.full      = full;
  assign sts.pow_done  = ($signed({1'b0, k_r}) > hp_eff);
  assign sts.scan_done = !scan_more && !rd_v_r;

  assign cfg_hp = hp_r;
  assign cfg_wl = wl_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_ring) begin
      ring_s[slot_r] <= x_r;
      ring_w[slot_r] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_s_r <= ring_s[rd_addr];
      rd_w_r <= ring_w[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r    <= mwps_pkg::HP_RESET;
      wl_r    <= '0;
      cnt_r   <= '0;
      slot_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      ovf_r   <= 1'b0;
      err_r   <= 1'b0;
      mode_r  <= mwps_pkg::MODE_ACC;
      k_r     <= '0;
      neg_r   <= 1'b0;
      rd_v_r  <= 1'b0;
      first_r <= 1'b0;
      scan_i_r <= '0;
      for (int k = 0; k < mwps_pkg::NPOW; k++) begin
        sum_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_idx == mwps_pkg::REG_HIGHEST_POWER) begin
        hp_r <= cfg_wdata[3:0];
      end else begin
        wl_r <= cfg_wdata[10:0];
      end
      cnt_r  <= '0;
      slot_r <= '0;
      min_r  <= '0;
      max_r  <= '0;
      ovf_r  <= 1'b0;
      for (int k = 0; k < mwps_pkg::NPOW; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        x_r    <= x_in;
        w_r    <= in_weight;
        mode_r <= in_mode;
        prod_r <= PROD_W'(in_weight);
        mx_r   <= x_in;
        k_r    <= '0;
        neg_r  <= (in_mode == mwps_pkg::MODE_DEC);
        err_r  <= (in_mode == mwps_pkg::MODE_DEC) && (win || ($signed(cnt_r) <= 0));
        unique case (in_mode)
          mwps_pkg::MODE_CLR: begin
            cnt_r  <= '0;
            slot_r <= '0;
            min_r  <= '0;
            max_r  <= '0;
            ovf_r  <= 1'b0;
            for (int k = 0; k < mwps_pkg::NPOW; k++) begin
              sum_r[k] <= '0;
            end
          end
          mwps_pkg::MODE_ACC: begin
            if (!win) begin
              if (cnt_r == '0) begin
                min_r <= x_in;
                max_r <= x_in;
              end else begin
                if (x_in < min_r) min_r <= x_in;
                if (x_in > max_r) max_r <= x_in;
              end
              cnt_r <= cnt_r + 32'd1;
            end
          end
          mwps_pkg::MODE_DEC: begin
            if (!win) cnt_r <= cnt_r - 32'd1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.step) begin
        sum_r[k_r] <= sum_res;
        if (sum_ovf) ovf_r <= 1'b1;
        prod_r <= prod_nxt;
        k_r    <= k_r + 3'd1;
      end
      if (cmd.load_old) begin
        prod_r <= PROD_W'(rd_w_r);
        mx_r   <= rd_s_r;
        k_r    <= '0;
        neg_r  <= 1'b1;
      end
      if (cmd.wr_ring) begin
        cnt_r  <= full ? 32'(len) : (cnt_r + 32'd1);
        slot_r <= (slot_p1 >= (LEN_W+1)'(len)) ? '0 : AW'(slot_p1);
      end
      if (cmd.scan_start) begin
        scan_i_r <= '0;
        first_r  <= 1'b1;
        rd_v_r   <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_v_r <= scan_more;
        if (scan_more) scan_i_r <= scan_i_r + LEN_W'(1);
        if (rd_v_r) begin
          first_r <= 1'b0;
          if (first_r) begin
            min_r <= rd_s_r;
            max_r <= rd_s_r;
          end else begin
            if (rd_s_r < min_r) min_r <= rd_s_r;
            if (rd_s_r > max_r) max_r <= rd_s_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count         <= cnt_r;
      out_sum_power0    <= (hp_eff >= 4'sd0) ? sum_r[0] : '0;
      out_sum_power1    <= (hp_eff >= 4'sd1) ? sum_r[1] : '0;
      out_sum_power2    <= (hp_eff >= 4'sd2) ? sum_r[2] : '0;
      out_sum_power3    <= (hp_eff >= 4'sd3) ? sum_r[3] : '0;
      out_sum_power4    <= (hp_eff >= 4'sd4) ? sum_r[4] : '0;
      out_data_min      <= ($signed(cnt_r) > 0) ? 12'($unsigned(min_r)) : '0;
      out_data_max      <= ($signed(cnt_r) > 0) ? 12'($unsigned(max_r)) : '0;
      out_overflow_flag <= ovf_r;
      out_error_flag    <= err_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mwps_ctrl.sv */
`default_nettype none
module mwps_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire mwps_pkg::mwps_sts_t sts,
  output mwps_pkg::mwps_cmd_t      cmd
);

  mwps_pkg::mwps_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == mwps_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mwps_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mwps_pkg::ST_DECODE;
      end
      mwps_pkg::ST_DECODE: begin
        if ((sts.mode == mwps_pkg::MODE_ACC) ||
            ((sts.mode == mwps_pkg::MODE_DEC) && !sts.win)) begin
          state_nxt = mwps_pkg::ST_ADD;
        end else begin
          state_nxt = mwps_pkg::ST_SCAN_INIT;
        end
      end
      mwps_pkg::ST_ADD: begin
        if (sts.pow_done) begin
          priority if (!sts.win || (sts.mode != mwps_pkg::MODE_ACC)) begin
            state_nxt = mwps_pkg::ST_SCAN_INIT;
          end else if (sts.full) begin
            state_nxt = mwps_pkg::ST_RD_OLD;
          end else begin
            state_nxt = mwps_pkg::ST_WR;
          end
        end
      end
      mwps_pkg::ST_RD_OLD:    state_nxt = mwps_pkg::ST_LD_OLD;
      mwps_pkg::ST_LD_OLD:    state_nxt = mwps_pkg::ST_SUB;
      mwps_pkg::ST_SUB: begin
        if (sts.pow_done) state_nxt = mwps_pkg::ST_WR;
      end
      mwps_pkg::ST_WR:        state_nxt = mwps_pkg::ST_SCAN_INIT;
      mwps_pkg::ST_SCAN_INIT: state_nxt = mwps_pkg::ST_SCAN;
      mwps_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = mwps_pkg::ST_OUT;
      end
      mwps_pkg::ST_OUT: begin
        if (out_free) state_nxt = mwps_pkg::ST_IDLE;
      end
      default: state_nxt = mwps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == mwps_pkg::ST_IDLE) && in_valid;
    cmd.step       = ((state_r == mwps_pkg::ST_ADD) || (state_r == mwps_pkg::ST_SUB)) &&
                     !sts.pow_done;
    cmd.rd_slot    = (state_r == mwps_pkg::ST_RD_OLD);
    cmd.load_old   = (state_r == mwps_pkg::ST_LD_OLD);
    cmd.wr_ring    = (state_r == mwps_pkg::ST_WR);
    cmd.scan_start = (state_r == mwps_pkg::ST_SCAN_INIT);
    cmd.scan_step  = (state_r == mwps_pkg::ST_SCAN);
    cmd.out_load   = (state_r == mwps_pkg::ST_OUT) && out_free;
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/moving_window_power_sums_core.sv */
// Window mode rescans the held entries for the min/max after each item, reading one
// ring entry a cycle through the single memory read port.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous active-low rst_n clears control, counts, sums, extremes and flags;
// the sample and weight rings are not cleared and need no clearing pass.
`default_nettype none
module moving_window_power_sums_core #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mwps_in_if.sink          in_ch,
  mwps_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  mwps_pkg::mwps_cmd_t cmd;
  mwps_pkg::mwps_sts_t sts;
  logic                cfg_we;
  logic [3:0]          cfg_hp;
  logic [10:0]         cfg_wl;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      mwps_pkg::REG_HIGHEST_POWER: cfg_prdata = {28'd0, cfg_hp};
      mwps_pkg::REG_WINDOW_LENGTH: cfg_prdata = {21'd0, cfg_wl};
      default:                     cfg_prdata = '0;
    endcase
  end

  mwps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mwps_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_ch.mode),
    .in_sample         (in_ch.sample),
    .in_weight         (in_ch.weight),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_paddr[2]),
    .cfg_wdata         (cfg_pwdata),
    .cfg_hp            (cfg_hp),
    .cfg_wl            (cfg_wl),
    .out_count         (out_ch.count),
    .out_sum_power0    (out_ch.sum_power0),
    .out_sum_power1    (out_ch.sum_power1),
    .out_sum_power2    (out_ch.sum_power2),
    .out_sum_power3    (out_ch.sum_power3),
    .out_sum_power4    (out_ch.sum_power4),
    .out_data_min      (out_ch.data_min),
    .out_data_max      (out_ch.data_max),
    .out_overflow_flag (out_ch.overflow_flag),
    .out_error_flag    (out_ch.error_flag)
  );

endmodule
`default_nettype wire

/* rtl/core/mwps_checker.sv */
`default_nettype none
`include "moving_window_power_sums_core_macros.svh"
module mwps_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_count,
  input wire logic signed [11:0] out_data_min,
  input wire logic signed [11:0] out_data_max
);

  `MWPS_ASSERT_NXT(a_busy_after_item, in_valid && in_ready, !in_ready, "ready after item")
  `MWPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_count), "result dropped")
  `MWPS_ASSERT_IMP(a_empty_extremes, out_valid && (out_count <= 0), (out_data_min == 12'sd0) && (out_data_max == 12'sd0), "extremes not zero when empty")

endmodule

bind moving_window_power_sums_core mwps_checker u_mwps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_count    (out_ch.count),
  .out_data_min (out_ch.data_min),
  .out_data_max (out_ch.data_max)
);
`default_nettype wire
